// ----- rtl/rgb_to_hsv_converter_core_macros.svh -----
// assertion macros used by the checker of the converter
`ifndef RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define RHC_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed: label");

// clocked assertion that also holds while reset is asserted
`define RHC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed: label");

`endif

// ----- rtl/rhc_pkg.sv -----
`timescale 1ns / 1ps

package rhc_pkg;

  // fixed field widths
  localparam int CH_W    = 8;
  localparam int TOTAL_W = 17;
  localparam int HUE_W   = 15;
  localparam int SAT_W   = 9;

  // default fraction bits
  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int SAT_FRAC_BITS_DEF = 8;

  // sector arithmetic in degrees
  localparam int DEG_SECTOR = 60;
  localparam int DEG_FULL   = 360;

  // channel masks of the packed colour
  localparam logic [23:0] CH_MASK_G = 24'h00FF00;
  localparam logic [23:0] CH_MASK_B = 24'hFF0000;

  // classified item as it waits between front and back
  typedef struct packed {
    logic [TOTAL_W-1:0] total;    // hue numerator in whole degrees times delta
    logic [CH_W-1:0]    hue_div;  // delta, or 1 for grey and black
    logic [CH_W-1:0]    delta;    // max minus min
    logic [CH_W-1:0]    sat_div;  // max, or 1 for black
    logic [CH_W-1:0]    value;    // max channel
  } rhc_item_t;

endpackage

// ----- rtl/rhc_front.sv -----
`timescale 1ns / 1ps

module rhc_front (
  input  logic [23:0]       color_i,
  output rhc_pkg::rhc_item_t item_o
);

  logic [rhc_pkg::CH_W-1:0] red;
  logic [rhc_pkg::CH_W-1:0] green;
  logic [rhc_pkg::CH_W-1:0] blue;
  logic [rhc_pkg::CH_W-1:0] max_ch;
  logic [rhc_pkg::CH_W-1:0] min_ch;
  logic [rhc_pkg::CH_W-1:0] delta;
  logic signed [18:0]       diff_s;
  logic signed [18:0]       base_s;
  logic signed [18:0]       total_s;

  // unpack channels and find the extremes
  always_comb begin
    red    = color_i[7:0];
    green  = 8'((color_i & rhc_pkg::CH_MASK_G) >> 8);
    blue   = 8'((color_i & rhc_pkg::CH_MASK_B) >> 16);
    min_ch = red;
    max_ch = red;
    if (green < min_ch) min_ch = green;
    if (blue < min_ch) min_ch = blue;
    if (green > max_ch) max_ch = green;
    if (blue > max_ch) max_ch = blue;
    delta = max_ch - min_ch;
  end

  // pick the sector, red first, then green, then blue
  always_comb begin
    priority if (red == max_ch) begin
      base_s = '0;
      diff_s = $signed({11'd0, green}) - $signed({11'd0, blue});
    end else if (green == max_ch) begin
      base_s = $signed({11'd0, delta}) * $signed(19'(2 * rhc_pkg::DEG_SECTOR));
      diff_s = $signed({11'd0, blue}) - $signed({11'd0, red});
    end else begin
      base_s = $signed({11'd0, delta}) * $signed(19'(4 * rhc_pkg::DEG_SECTOR));
      diff_s = $signed({11'd0, red}) - $signed({11'd0, green});
    end
    total_s = base_s + $signed(19'(rhc_pkg::DEG_SECTOR)) * diff_s;
    // wrap negative hue into the full circle
    if (total_s < 0) begin
      total_s = total_s + $signed({11'd0, delta}) * $signed(19'(rhc_pkg::DEG_FULL));
    end
  end

  // grey and black divide zero by one so both quotients come out zero
  always_comb begin
    item_o.total   = (delta == '0) ? '0 : total_s[rhc_pkg::TOTAL_W-1:0];
    item_o.hue_div = (delta == '0) ? 8'd1 : delta;
    item_o.delta   = delta;
    item_o.sat_div = (max_ch == '0) ? 8'd1 : max_ch;
    item_o.value   = max_ch;
  end

endmodule

// ----- rtl/rhc_queue.sv -----
`timescale 1ns / 1ps

module rhc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  rhc_pkg::rhc_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output rhc_pkg::rhc_item_t pop_item_o
);

  rhc_pkg::rhc_item_t entry_q [2];
  logic               wr_ptr_q;
  logic               wr_ptr_d;
  logic               rd_ptr_q;
  logic               rd_ptr_d;
  logic [1:0]         count_q;
  logic [1:0]         count_d;
  logic               push;
  logic               pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/rhc_back.sv -----
`timescale 1ns / 1ps

module rhc_back #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  output logic                      item_ready_o,
  input  rhc_pkg::rhc_item_t        item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rhc_pkg::HUE_W-1:0] hue_o,
  output logic [rhc_pkg::SAT_W-1:0] saturation_o,
  output logic [rhc_pkg::CH_W-1:0]  value_o
);

  localparam int HUE_NUM_W = rhc_pkg::TOTAL_W + HUE_FRAC_BITS;
  localparam int SAT_NUM_W = rhc_pkg::CH_W + SAT_FRAC_BITS;
  localparam int NUM_W     = (HUE_NUM_W > SAT_NUM_W) ? HUE_NUM_W : SAT_NUM_W;
  localparam int STAGES    = NUM_W;
  localparam int CW        = rhc_pkg::CH_W;

  // per stage: word holds the unconsumed numerator on top, quotient bits below
  logic             valid_q [STAGES];
  logic [NUM_W-1:0] hw_q    [STAGES];
  logic [NUM_W-1:0] hw_d    [STAGES];
  logic [CW-1:0]    hrem_q  [STAGES];
  logic [CW-1:0]    hrem_d  [STAGES];
  logic [CW-1:0]    hdiv_q  [STAGES];
  logic [NUM_W-1:0] sw_q    [STAGES];
  logic [NUM_W-1:0] sw_d    [STAGES];
  logic [CW-1:0]    srem_q  [STAGES];
  logic [CW-1:0]    srem_d  [STAGES];
  logic [CW-1:0]    sdiv_q  [STAGES];
  logic [CW-1:0]    val_q   [STAGES];
  logic             advance;

  // whole pipeline moves when the last stage is empty or being taken
  assign advance      = !valid_q[STAGES-1] || out_ready_i;
  assign item_ready_o = advance;

  // one restoring division step per stage on both lanes
  always_comb begin
    logic [NUM_W-1:0] hw_src;
    logic [NUM_W-1:0] sw_src;
    logic [CW-1:0]    hrem_src;
    logic [CW-1:0]    srem_src;
    logic [CW-1:0]    hdiv_src;
    logic [CW-1:0]    sdiv_src;
    logic [CW:0]      htrial;
    logic [CW:0]      strial;
    logic             hbit;
    logic             sbit;
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        hw_src   = NUM_W'(item_i.total) << HUE_FRAC_BITS;
        sw_src   = NUM_W'(item_i.delta) << SAT_FRAC_BITS;
        hrem_src = '0;
        srem_src = '0;
        hdiv_src = item_i.hue_div;
        sdiv_src = item_i.sat_div;
      end else begin
        hw_src   = hw_q[s-1];
        sw_src   = sw_q[s-1];
        hrem_src = hrem_q[s-1];
        srem_src = srem_q[s-1];
        hdiv_src = hdiv_q[s-1];
        sdiv_src = sdiv_q[s-1];
      end
      htrial = {hrem_src, hw_src[NUM_W-1]};
      strial = {srem_src, sw_src[NUM_W-1]};
      hbit   = (htrial >= {1'b0, hdiv_src});
      sbit   = (strial >= {1'b0, sdiv_src});
      hrem_d[s] = hbit ? CW'(htrial - {1'b0, hdiv_src}) : htrial[CW-1:0];
      srem_d[s] = sbit ? CW'(strial - {1'b0, sdiv_src}) : strial[CW-1:0];
      hw_d[s]   = {hw_src[NUM_W-2:0], hbit};
      sw_d[s]   = {sw_src[NUM_W-2:0], sbit};
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) valid_q[s] <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= item_valid_i;
      for (int s = 1; s < STAGES; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int s = 0; s < STAGES; s++) begin
        hw_q[s]   <= hw_d[s];
        sw_q[s]   <= sw_d[s];
        hrem_q[s] <= hrem_d[s];
        srem_q[s] <= srem_d[s];
      end
      hdiv_q[0] <= item_i.hue_div;
      sdiv_q[0] <= item_i.sat_div;
      val_q[0]  <= item_i.value;
      for (int s = 1; s < STAGES; s++) begin
        hdiv_q[s] <= hdiv_q[s-1];
        sdiv_q[s] <= sdiv_q[s-1];
        val_q[s]  <= val_q[s-1];
      end
    end
  end

  // last stage is the output register
  assign out_valid_o  = valid_q[STAGES-1];
  assign hue_o        = hw_q[STAGES-1][rhc_pkg::HUE_W-1:0];
  assign saturation_o = sw_q[STAGES-1][rhc_pkg::SAT_W-1:0];
  assign value_o      = val_q[STAGES-1];

endmodule

// ----- rtl/rgb_to_hsv_converter_core.sv -----
// the front classifies combinationally, the queue registers the item and the divider pipeline
//   then yields one quotient bit per stage, its last stage being the output register
// throughput: one colour per cycle while the output side keeps taking results
// a two-entry queue parts the classifying front from the divider pipeline
// reset: asynchronous, active low; clears queue count and stage valid bits, no result pending
`timescale 1ns / 1ps

module rgb_to_hsv_converter_core #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [23:0]               color_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rhc_pkg::HUE_W-1:0] hue_o,
  output logic [rhc_pkg::SAT_W-1:0] saturation_o,
  output logic [rhc_pkg::CH_W-1:0]  value_o
);

  rhc_pkg::rhc_item_t front_item;
  rhc_pkg::rhc_item_t queue_item;
  logic               queue_valid;
  logic               back_ready;

  // unpack and classify the colour
  rhc_front u_front (
    .color_i (color_i),
    .item_o  (front_item)
  );

  // short queue between front and back
  rhc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (queue_item)
  );

  // divider pipeline and output register
  rhc_back #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_ready_o (back_ready),
    .item_i       (queue_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o)
  );

endmodule

// ----- rtl/rhc_checker.sv -----
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_core_macros.svh"

module rhc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [rhc_pkg::HUE_W-1:0] hue_o,
  input logic [rhc_pkg::SAT_W-1:0] saturation_o,
  input logic [rhc_pkg::CH_W-1:0]  value_o
);

  localparam int PAYLOAD_W = rhc_pkg::HUE_W + rhc_pkg::SAT_W + rhc_pkg::CH_W;

  logic                 out_stall;
  logic                 out_black;
  logic                 black_zero;
  logic [PAYLOAD_W-1:0] out_payload;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_black   = out_valid_o && (value_o == '0);
  assign black_zero  = (hue_o == '0) && (saturation_o == '0);
  assign out_payload = {hue_o, saturation_o, value_o};

  // a stalled result stays offered
  `RHC_ASSERT_CLK(a_out_valid_hold, clk_i, rst_ni, out_stall |=> out_valid_o)

  // a stalled result keeps its payload
  `RHC_ASSERT_CLK(a_out_payload_hold, clk_i, rst_ni, out_stall |=> $stable(out_payload))

  // black gives zero hue and zero saturation
  `RHC_ASSERT_CLK(a_black_zero, clk_i, rst_ni, out_black |-> black_zero)

  // nothing is offered while reset is held
  `RHC_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int HUE_FRAC       = rhc_pkg::HUE_FRAC_BITS_DEF;
  localparam int SAT_FRAC       = rhc_pkg::SAT_FRAC_BITS_DEF;
  localparam int RANDOM_COLOURS = 935;
  localparam int CALM_TAIL      = 150;
  localparam int PAUSE_AT       = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [rhc_pkg::HUE_W-1:0] hue;
    logic [rhc_pkg::SAT_W-1:0] sat;
    logic [rhc_pkg::CH_W-1:0]  value;
  } hsv_t;

  typedef struct packed {
    logic [23:0] color;
    bit          typed;
    hsv_t        want;
  } colour_row_t;

  logic                      clk_i;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic [23:0]               color_i      = '0;
  logic                      out_ready_i  = 1'b0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic [rhc_pkg::HUE_W-1:0] hue_o;
  logic [rhc_pkg::SAT_W-1:0] saturation_o;
  logic [rhc_pkg::CH_W-1:0]  value_o;

  // expected conversions in transfer order
  hsv_t hsv_expected[$];
  bit   cur_typed;
  hsv_t cur_want;
  bit   in_fire, out_fire;
  bit   idle_on = 1'b1;
  int   stall_left;
  int   idle_cycles;
  int   mismatch_count;

  // black, white, greys, primaries, tie-breaks and hue near the wrap
  colour_row_t colour_rows [18] = '{
    '{24'h000000, 1'b1, '{15'd0,     9'd0,   8'd0}},
    '{24'hFFFFFF, 1'b1, '{15'd0,     9'd0,   8'd255}},
    '{24'h808080, 1'b1, '{15'd0,     9'd0,   8'd128}},
    '{24'h010101, 1'b1, '{15'd0,     9'd0,   8'd1}},
    '{24'h0000FF, 1'b1, '{15'd0,     9'd256, 8'd255}},
    '{24'h00FF00, 1'b1, '{15'd7680,  9'd256, 8'd255}},
    '{24'hFF0000, 1'b1, '{15'd15360, 9'd256, 8'd255}},
    '{24'h00FFFF, 1'b1, '{15'd3840,  9'd256, 8'd255}},
    '{24'hFFFF00, 1'b1, '{15'd11520, 9'd256, 8'd255}},
    '{24'hFF00FF, 1'b1, '{15'd19200, 9'd256, 8'd255}},
    '{24'h010000, 1'b1, '{15'd15360, 9'd256, 8'd1}},
    '{24'h0100FF, 1'b0, '{15'd0,     9'd0,   8'd0}},
    '{24'hFE00FF, 1'b0, '{15'd0,     9'd0,   8'd0}},
    '{24'hFFFE01, 1'b0, '{15'd0,     9'd0,   8'd0}},
    '{24'h7F80FE, 1'b0, '{15'd0,     9'd0,   8'd0}},
    '{24'h80FF7F, 1'b0, '{15'd0,     9'd0,   8'd0}},
    '{24'h123456, 1'b0, '{15'd0,     9'd0,   8'd0}},
    '{24'hABCDEF, 1'b0, '{15'd0,     9'd0,   8'd0}}
  };

  rgb_to_hsv_converter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .color_i      (color_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hue, saturation and value of one packed colour, quotients truncated
  function automatic hsv_t hsv_of_color(input logic [23:0] c);
    longint red, grn, blu, hi, lo, span, total, hue_q, sat_q;
    hsv_t   res;
    red = longint'(c[7:0]);
    grn = longint'(c[15:8]);
    blu = longint'(c[23:16]);
    hi  = red;
    lo  = red;
    if (grn < lo) lo = grn;
    if (blu < lo) lo = blu;
    if (grn > hi) hi = grn;
    if (blu > hi) hi = blu;
    span  = hi - lo;
    hue_q = 0;
    sat_q = 0;
    if (hi != 0) begin
      sat_q = (span << SAT_FRAC) / hi;
      // grey leaves hue at zero
      if (span != 0) begin
        if (red == hi) begin
          total = rhc_pkg::DEG_SECTOR * (grn - blu);
        end else if (grn == hi) begin
          total = 2 * rhc_pkg::DEG_SECTOR * span + rhc_pkg::DEG_SECTOR * (blu - red);
        end else begin
          total = 4 * rhc_pkg::DEG_SECTOR * span + rhc_pkg::DEG_SECTOR * (red - grn);
        end
        if (total < 0) total += rhc_pkg::DEG_FULL * span;
        if (total < 0) total = 0;
        hue_q = (total << HUE_FRAC) / span;
      end
    end
    res.hue   = hue_q[rhc_pkg::HUE_W-1:0];
    res.sat   = sat_q[rhc_pkg::SAT_W-1:0];
    res.value = hi[rhc_pkg::CH_W-1:0];
    return res;
  endfunction

  // random colour biased towards greys, ties, near-greys and channel extremes
  function automatic logic [23:0] rand_color();
    logic [7:0] a, b;
    logic [7:0] ch [3];
    int         odd;
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      5: return {a, a, a};
      6: begin
        odd = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) ch[i] = (i == odd) ? b : a;
        return {ch[2], ch[1], ch[0]};
      end
      7: return {a ^ 8'($urandom_range(0, 3)), a ^ 8'($urandom_range(0, 3)),
                 a ^ 8'($urandom_range(0, 3))};
      8: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 3))
            0: ch[i] = 8'd0;
            1: ch[i] = 8'd1;
            2: ch[i] = 8'd254;
            default: ch[i] = 8'd255;
          endcase
        end
        return {ch[2], ch[1], ch[0]};
      end
      9: return ($urandom_range(0, 1) != 0) ? 24'h000000 : {16'h0000, a} << (8 * (b % 3));
      default: return 24'($urandom);
    endcase
  endfunction

  // offer one colour and hold it until the transfer
  task automatic send_color(input logic [23:0] c, input bit typed, input hsv_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    color_i    <= c;
    cur_typed   = typed;
    cur_want    = want;
    do @(negedge clk_i); while (!in_fire);
  endtask

  // result side stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 9);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // transfers, result check and watchdog
  always @(posedge clk_i) begin : monitor
    hsv_t want;
    if (rst_ni) begin
      in_fire  = in_valid_i && in_ready_o;
      out_fire = out_valid_o && out_ready_i;
      if (out_fire) begin
        if (hsv_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t unexpected result hue %0d sat %0d value %0d",
                     $realtime, hue_o, saturation_o, value_o);
        end else begin
          want = hsv_expected.pop_front();
          if (hue_o !== want.hue || saturation_o !== want.sat || value_o !== want.value) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t mismatch hue %0d/%0d sat %0d/%0d value %0d/%0d (exp/got)",
                       $realtime, want.hue, hue_o, want.sat, saturation_o,
                       want.value, value_o);
          end
        end
      end
      if (in_fire) hsv_expected.push_back(cur_typed ? cur_want : hsv_of_color(color_i));
      if (in_fire || out_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed colours
    foreach (colour_rows[i])
      send_color(colour_rows[i].color, colour_rows[i].typed, colour_rows[i].want);

    // random colours, calm at the end
    for (int n = 0; n < RANDOM_COLOURS; n++) begin
      if (n == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        while (hsv_expected.size() != 0) @(negedge clk_i);
      end
      if (n == RANDOM_COLOURS - CALM_TAIL) idle_on = 1'b0;
      send_color(rand_color(), 1'b0, '0);
    end

    // drain the pipeline
    in_valid_i <= 1'b0;
    while (hsv_expected.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
